// ----- src/tbit_pkg.sv -----
package tbit_pkg;

  // Quotient bits produced by the divider, one per stage.
  localparam int QBITS = 32;
  // Divider depth: setup stage plus one stage per quotient bit.
  localparam int DIV_STAGES = QBITS + 1;

  // Steering bundle that follows one request through the divider stages.
  typedef struct packed {
    logic in_tri;
    logic degenerate;
  } flags_t;

endpackage

// ----- src/triangle_barycentric_inside_test.sv -----
// Barycentric point-in-triangle test.
// Input channel: valid_i/stall_o with vertices A, B, C and point P in signed
// 12.4 fixed point. Output channel: valid_o/stall_i with inside_res, degenerate
// and three signed Q(31-F).F weights truncated toward zero and saturated.
// Throughput: one request per cycle unless the receiver stalls. Each request
// passes the register stages in order: edge, product and sum stages, the divider
// stages (magnitude and overflow setup, then one quotient bit per stage, three
// dividers side by side) and the output register.
// The whole pipe advances together; a stall from the receiver freezes every
// stage and stall_o follows at once when the output register is full, so no
// request is lost or repeated. Reset clears all valid bits; data registers
// are not reset.
module triangle_barycentric_inside_test #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] ax_i,
  input  logic signed [COORD_WIDTH-1:0] ay_i,
  input  logic signed [COORD_WIDTH-1:0] bx_i,
  input  logic signed [COORD_WIDTH-1:0] by_i,
  input  logic signed [COORD_WIDTH-1:0] cx_i,
  input  logic signed [COORD_WIDTH-1:0] cy_i,
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic                          inside_res_o,
  output logic                          degenerate_o,
  output logic signed [31:0]            weight_u_o,
  output logic signed [31:0]            weight_v_o,
  output logic signed [31:0]            weight_w_o
);
  localparam int NW = 2 * COORD_WIDTH + 4;
  localparam int DL = tbit_pkg::DIV_STAGES;

  logic                 adv, fv;
  logic signed [NW-1:0] det, nu, nv, nw;
  logic [31:0]          qu, qv, qw;
  logic                 out_v_q;

  // Advance whenever the output slot is empty or being taken.
  assign adv     = !out_v_q || !stall_i;
  assign stall_o = !adv;

  tbit_front #(.CW(COORD_WIDTH), .NW(NW)) u_front (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i,
    .ax_i, .ay_i, .bx_i, .by_i, .cx_i, .cy_i, .px_i, .py_i,
    .valid_o(fv), .det_o(det), .nu_o(nu), .nv_o(nv), .nw_o(nw)
  );

  tbit_div #(.NW(NW), .FB(WEIGHT_FRAC_BITS)) u_du (
    .clk_i, .adv_i(adv), .num_i(nu), .den_i(det), .q_o(qu));
  tbit_div #(.NW(NW), .FB(WEIGHT_FRAC_BITS)) u_dv (
    .clk_i, .adv_i(adv), .num_i(nv), .den_i(det), .q_o(qv));
  tbit_div #(.NW(NW), .FB(WEIGHT_FRAC_BITS)) u_dw (
    .clk_i, .adv_i(adv), .num_i(nw), .den_i(det), .q_o(qw));

  // Sign checks on exact numerators, delayed alongside the dividers.
  tbit_pkg::flags_t fl;
  tbit_pkg::flags_t fl_q [DL];
  logic             vd_q [DL];
  logic             dz;
  assign dz = (det == '0);
  assign fl.degenerate = dz;
  assign fl.in_tri = !dz
      && (nu == '0 || nu[NW-1] == det[NW-1])
      && (nv == '0 || nv[NW-1] == det[NW-1])
      && (nw == '0 || nw[NW-1] == det[NW-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DL; k++) vd_q[k] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      vd_q[0] <= fv;
      for (int k = 1; k < DL; k++) vd_q[k] <= vd_q[k-1];
      out_v_q <= vd_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fl_q[0] <= fl;
      for (int k = 1; k < DL; k++) fl_q[k] <= fl_q[k-1];
      inside_res_o <= fl_q[DL-1].in_tri;
      degenerate_o <= fl_q[DL-1].degenerate;
      weight_u_o   <= fl_q[DL-1].degenerate ? '0 : qu;
      weight_v_o   <= fl_q[DL-1].degenerate ? '0 : qv;
      weight_w_o   <= fl_q[DL-1].degenerate ? '0 : qw;
    end
  end

  assign valid_o = out_v_q;

endmodule

// ----- src/tbit_front.sv -----
module tbit_front #(
  parameter int CW = 16,
  parameter int NW = 2 * CW + 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] ax_i,
  input  logic signed [CW-1:0] ay_i,
  input  logic signed [CW-1:0] bx_i,
  input  logic signed [CW-1:0] by_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  output logic                 valid_o,
  output logic signed [NW-1:0] det_o,
  output logic signed [NW-1:0] nu_o,
  output logic signed [NW-1:0] nv_o,
  output logic signed [NW-1:0] nw_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic                 v1_q, v2_q, v3_q;
  logic signed [DW-1:0] e1y_q, e1x_q, e2y_q, e2x_q, ex_q, ey_q, dx_q, dy_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [NW-1:0] det_q, nu_q, nw_q, nv_q;

  // Stage 1: edge vectors.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e1y_q <= DW'(by_i) - DW'(cy_i);
      e1x_q <= DW'(cx_i) - DW'(bx_i);
      e2y_q <= DW'(cy_i) - DW'(ay_i);
      e2x_q <= DW'(ax_i) - DW'(cx_i);
      ex_q  <= DW'(ax_i) - DW'(cx_i);
      ey_q  <= DW'(ay_i) - DW'(cy_i);
      dx_q  <= DW'(px_i) - DW'(cx_i);
      dy_q  <= DW'(py_i) - DW'(cy_i);
      // Stage 2: six products.
      p0_q <= PW'(e1y_q) * PW'(ex_q);
      p1_q <= PW'(e1x_q) * PW'(ey_q);
      p2_q <= PW'(e1y_q) * PW'(dx_q);
      p3_q <= PW'(e1x_q) * PW'(dy_q);
      p4_q <= PW'(e2y_q) * PW'(dx_q);
      p5_q <= PW'(e2x_q) * PW'(dy_q);
      // Stage 3: sums.
      det_q <= NW'(p0_q) + NW'(p1_q);
      nw_q  <= NW'(p2_q) + NW'(p3_q);
      nu_q  <= NW'(p4_q) + NW'(p5_q);
      nv_q  <= NW'(p0_q) + NW'(p1_q) - NW'(p2_q) - NW'(p3_q) - NW'(p4_q) - NW'(p5_q);
    end
  end

  assign valid_o = v3_q;
  assign det_o   = det_q;
  assign nu_o    = nu_q;
  assign nv_o    = nv_q;
  assign nw_o    = nw_q;

endmodule

// ----- src/tbit_div.sv -----
// Pipelined restoring divider: magnitude quotient of num*2^F/den, one bit per stage,
// truncated toward zero, saturated to a signed 32-bit result.
module tbit_div #(
  parameter int NW = 36,
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [NW-1:0] den_i,
  output logic        [31:0]   q_o
);

  localparam int QB = tbit_pkg::QBITS;
  localparam int RW = NW + 1;
  localparam int XW = NW + FB;

  logic [NW-1:0] nmag, dmag;
  logic          neg;
  logic [XW-1:0] x0;
  logic          ov_d;

  assign nmag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign dmag = den_i[NW-1] ? NW'(-den_i) : NW'(den_i);
  assign neg  = num_i[NW-1] ^ den_i[NW-1];
  assign x0   = XW'(nmag) << FB;
  // A quotient of 2^32 or more saturates.
  assign ov_d = (x0 >> QB) >= XW'(dmag);

  logic [QB-1:0] x_q  [QB];
  logic [RW-1:0] r_q  [QB];
  logic [NW-1:0] d_q  [QB];
  logic [QB-1:0] qq_q [QB+1];
  logic          ov_q [QB+1];
  logic          ng_q [QB+1];

  // Stage 0: start with the high dividend bits as the remainder.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]  <= QB'(x0);
      r_q[0]  <= RW'(x0 >> QB);
      d_q[0]  <= dmag;
      qq_q[0] <= '0;
      ov_q[0] <= ov_d;
      ng_q[0] <= neg;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_st
    logic [RW-1:0] rs;
    logic          ge;
    assign rs = {r_q[s][RW-2:0], x_q[s][QB-1]};
    assign ge = rs >= RW'(d_q[s]);
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        qq_q[s+1] <= {qq_q[s][QB-2:0], ge};
        ov_q[s+1] <= ov_q[s];
        ng_q[s+1] <= ng_q[s];
      end
    end
    if (s < QB - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          x_q[s+1] <= x_q[s] << 1;
          r_q[s+1] <= ge ? rs - RW'(d_q[s]) : rs;
          d_q[s+1] <= d_q[s];
        end
      end
    end
  end

  logic [31:0] mag;
  logic [31:0] lim;
  logic        sat;
  assign lim = ng_q[QB] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign sat = ov_q[QB] | (qq_q[QB] > lim);
  assign mag = sat ? lim : qq_q[QB];
  assign q_o = ng_q[QB] ? 32'(-mag) : mag;

endmodule

// ----- src/tbit_check.sv -----
module tbit_check (
  input logic clk_i,
  input logic rst_ni,
  input logic stall_o,
  input logic valid_o,
  input logic stall_i,
  input logic inside_res_o,
  input logic degenerate_o
);

  a_deg_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(degenerate_o && inside_res_o)) else $error("degenerate and inside");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i) else $error("stall without full output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(inside_res_o)) else $error("output dropped");

endmodule

bind triangle_barycentric_inside_test tbit_check u_check (
  .clk_i, .rst_ni, .stall_o, .valid_o, .stall_i, .inside_res_o, .degenerate_o
);

// ----- tb/sv/tb_top.sv -----
module tb_top;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int N_RANDOM = 650;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic        in_tri;
    logic        degen;
    logic [31:0] wu;
    logic [31:0] wv;
    logic [31:0] ww;
  } weights_t;

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic                 known;   // expected result typed in below
    weights_t             res;
  } tri_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o;
  logic signed [CW-1:0] ax_i = '0, ay_i = '0, bx_i = '0, by_i = '0;
  logic signed [CW-1:0] cx_i = '0, cy_i = '0, px_i = '0, py_i = '0;
  logic inside_res_o, degenerate_o;
  logic signed [31:0] weight_u_o, weight_v_o, weight_w_o;

  weights_t pending_weights[$];
  int       errors = 0;
  bit       stim_done = 1'b0;

  triangle_barycentric_inside_test #(
    .COORD_WIDTH(CW), .WEIGHT_FRAC_BITS(FB)
  ) dut (.*);

  always #5 clk_i = ~clk_i;

  // Divide num*2^F by den, truncate toward zero, saturate to 32 bits.
  function automatic logic [31:0] q_divide(longint num, longint den);
    longint unsigned n, d, q, r, lim, mag;
    bit neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    q = n / d;
    r = n % d;
    if (q >= (64'd1 << (32 - FB))) begin
      mag = lim;
    end else begin
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      mag = (q > lim) ? lim : q;
    end
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic bit same_side(longint n, longint det);
    return (n == 0) || ((n < 0) == (det < 0));
  endfunction

  function automatic weights_t barycentric(tri_row_t t);
    weights_t o;
    longint e1y, e1x, e2y, e2x, dx, dy, det, nw, nu, nv;
    e1y = longint'(t.by) - t.cy;
    e1x = longint'(t.cx) - t.bx;
    e2y = longint'(t.cy) - t.ay;
    e2x = longint'(t.ax) - t.cx;
    dx  = longint'(t.px) - t.cx;
    dy  = longint'(t.py) - t.cy;
    det = e1y * e2x + e1x * (longint'(t.ay) - t.cy);
    nw  = e1y * dx + e1x * dy;
    nu  = e2y * dx + e2x * dy;
    nv  = det - nw - nu;
    o = '{1'b0, 1'b1, 32'd0, 32'd0, 32'd0};
    if (det != 0) begin
      o.degen  = 1'b0;
      o.in_tri = same_side(nu, det) && same_side(nv, det) && same_side(nw, det);
      o.wu = q_divide(nu, det);
      o.wv = q_divide(nv, det);
      o.ww = q_divide(nw, det);
    end
    return o;
  endfunction

  function automatic tri_row_t mk(int ax, int ay, int bx, int by, int cx, int cy,
                                  int px, int py);
    tri_row_t t;
    t.ax = CW'(ax); t.ay = CW'(ay); t.bx = CW'(bx); t.by = CW'(by);
    t.cx = CW'(cx); t.cy = CW'(cy); t.px = CW'(px); t.py = CW'(py);
    t.known = 1'b0;
    t.res = '{1'b0, 1'b0, 32'd0, 32'd0, 32'd0};
    return t;
  endfunction

  function automatic tri_row_t mk_known(tri_row_t t, weights_t r);
    t.known = 1'b1;
    t.res = r;
    return t;
  endfunction

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return CW'($urandom_range(0, 63) - 32);
      2:       return CW'($urandom_range(0, 1023) - 512);
      default: return CW'($urandom());
    endcase
  endfunction

  // Mostly triangles of small to large span with a point nearby, some made collinear; the rest raw noise.
  function automatic tri_row_t rnd_triangle();
    tri_row_t t;
    int sel, base_x, base_y, span;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      t = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    end else begin
      span   = (sel < 5) ? 64 : ((sel < 8) ? 2048 : 16000);
      base_x = $urandom_range(0, 32000) - 16000;
      base_y = $urandom_range(0, 32000) - 16000;
      t = mk(base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
             base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
             base_x + $urandom_range(0, span), base_y + $urandom_range(0, span),
             base_x + $urandom_range(0, span), base_y + $urandom_range(0, span));
      if (sel == 9) begin
        // collinear vertices give a zero determinant
        t.cx = CW'(t.ax + 2 * (t.bx - t.ax));
        t.cy = CW'(t.ay + 2 * (t.by - t.ay));
      end
    end
    return t;
  endfunction

  // Hold the request until it is taken; valid stays high for the next request.
  task automatic send_request(tri_row_t t);
    ax_i <= t.ax; ay_i <= t.ay; bx_i <= t.bx; by_i <= t.by;
    cx_i <= t.cx; cy_i <= t.cy; px_i <= t.px; py_i <= t.py;
    valid_i <= 1'b1;
    do @(posedge clk_i); while (stall_o);
    pending_weights.push_back(t.known ? t.res : barycentric(t));
    @(negedge clk_i);
  endtask

  task automatic idle_cycles(int n);
    valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  initial begin
    tri_row_t rows[$];
    int burst;
    weights_t zero_degen;
    zero_degen = '{1'b0, 1'b1, 32'd0, 32'd0, 32'd0};

    // Directed table: all-zero, all-equal and collinear vertices are degenerate.
    rows.push_back(mk_known(mk(0, 0, 0, 0, 0, 0, 0, 0), zero_degen));
    rows.push_back(mk_known(mk(32767, 32767, 32767, 32767, 32767, 32767, 0, 0),
                            zero_degen));
    rows.push_back(mk_known(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                               32767, -32768), zero_degen));
    rows.push_back(mk_known(mk(0, 0, 16, 16, 32, 32, 5, 5), zero_degen));
    // Point at vertex C: weights 0, 1.0, 0.
    rows.push_back(mk_known(mk(0, 0, 16, 0, 0, 16, 0, 16),
                            '{1'b1, 1'b0, 32'd0, 32'h0001_0000, 32'd0}));
    // Point at vertex A and at vertex B.
    rows.push_back(mk_known(mk(0, 0, 16, 0, 0, 16, 0, 0),
                            '{1'b1, 1'b0, 32'd0, 32'd0, 32'h0001_0000}));
    rows.push_back(mk_known(mk(0, 0, 16, 0, 0, 16, 16, 0),
                            '{1'b1, 1'b0, 32'h0001_0000, 32'd0, 32'd0}));
    // On an edge, inside, outside, and the mirrored winding.
    rows.push_back(mk(0, 0, 16, 0, 0, 16, 8, 0));
    rows.push_back(mk(0, 0, 160, 0, 0, 160, 20, 30));
    rows.push_back(mk(0, 0, 160, 0, 0, 160, 200, 200));
    rows.push_back(mk(0, 0, 0, 160, 160, 0, 20, 30));
    rows.push_back(mk(0, 0, 0, 160, 160, 0, -20, 30));
    // Tiny triangle with a far point: quotients saturate both ways.
    rows.push_back(mk(0, 0, 1, 0, 0, 1, 32767, 32767));
    rows.push_back(mk(0, 0, 1, 0, 0, 1, -32768, 32767));
    rows.push_back(mk(0, 0, 0, 1, 1, 0, -32768, -32768));
    // Extreme-coordinate triangles.
    rows.push_back(mk(-32768, -32768, 32767, -32768, -32768, 32767, 0, 0));
    rows.push_back(mk(32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768));
    rows.push_back(mk(-32768, 32767, 32767, 32767, 0, -32768, 32767, -32768));
    rows.push_back(mk(3, -7, -11, 5, 13, 9, 1, 2));   // non-exact fractions

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_request(rows[i]);
    idle_cycles(1);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // hold off until the pipe has drained completely
        valid_i <= 1'b0;
        while (pending_weights.size() != 0) @(negedge clk_i);
      end
      send_request(rnd_triangle());
      if ($urandom_range(0, 7) == 0) begin
        burst = (n < 100) ? 0 : $urandom_range(1, 6);
        if (burst > 0) idle_cycles(burst);
      end
    end
    valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: stretches of free flow, random stalls and long stalls.
  initial begin
    int mode;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        @(negedge clk_i);
        case (mode)
          0:       stall_i <= 1'b0;
          1:       stall_i <= ($urandom_range(0, 3) == 0);
          2:       stall_i <= ($urandom_range(0, 1) == 0);
          default: stall_i <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    weights_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_weights.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = pending_weights.pop_front();
        if (inside_res_o !== e.in_tri) begin
          $error("inside_res: expected %0d, got %0d", e.in_tri, inside_res_o);
          errors++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate: expected %0d, got %0d", e.degen, degenerate_o);
          errors++;
        end
        if (weight_u_o !== e.wu) begin
          $error("weight_u: expected %h, got %h", e.wu, weight_u_o);
          errors++;
        end
        if (weight_v_o !== e.wv) begin
          $error("weight_v: expected %h, got %h", e.wv, weight_v_o);
          errors++;
        end
        if (weight_w_o !== e.ww) begin
          $error("weight_w: expected %h, got %h", e.ww, weight_w_o);
          errors++;
        end
      end
    end
  end

  // Drain, keep watching for stray results for a further DRAIN_CYCLES, then report.
  initial begin
    wait (stim_done);
    while (pending_weights.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending_weights.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- triangle_barycentric_inside_test.f -----
src/tbit_pkg.sv
src/tbit_front.sv
src/tbit_div.sv
src/triangle_barycentric_inside_test.sv
src/tbit_check.sv
tb/sv/tb_top.sv
